### rtl/core/lrcr_pkg.sv
// Package for the loop roll capture and replay block: register indexes,
// register widths and reset values, and the status bundle of the position unit.
// No dependencies.
`timescale 1ns / 1ps

package lrcr_pkg;

   // Configuration register map.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_WET_GAIN    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_FRAMES = 1'b1;

   // Register widths and reset values.
   localparam int WET_W    = 9;
   localparam int FRAMES_W = 17;
   localparam logic [WET_W-1:0]    WET_FULL        = 9'd256;
   localparam logic [WET_W-1:0]    WET_GAIN_RST    = 9'd256;
   localparam logic [FRAMES_W-1:0] LOOP_FRAMES_RST = 17'd22050;

   // Mix arithmetic: the gain is a fraction of 2**MIX_SHIFT.
   localparam int MIX_SHIFT = 8;

   // Status of the play position reduction unit.
   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

endpackage

### rtl/core/lrcr_pos_mod.sv
// Restoring remainder unit: reduces the play position modulo the loop length,
// one dividend bit per cycle. Depends on lrcr_pkg.
`timescale 1ns / 1ps

module lrcr_pos_mod #(
   parameter int POS_W = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [POS_W-1:0]       numer,
   input  logic [POS_W:0]         divisor,
   output logic [POS_W-1:0]       remainder,
   output lrcr_pkg::mod_stat_type stat
);

   localparam int CNT_W = $clog2(POS_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] num_ff, num_in;
   logic [POS_W-1:0] rem_ff, rem_in;
   logic [POS_W:0]   trial;
   logic             last_step;

   // The partial remainder stays below the divisor, so the shifted trial value
   // always fits one bit more than the position.
   assign trial     = {rem_ff, num_ff[POS_W-1]};
   assign last_step = (cnt_ff == CNT_W'(POS_W - 1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = numer;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[POS_W-2:0], 1'b0};
         if (trial >= divisor) begin
            rem_in = POS_W'(trial - divisor);
         end else begin
            rem_in = trial[POS_W-1:0];
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_in;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && last_step && !start;

endmodule

### rtl/core/loop_roll_capture_replay.sv
// Top level of the loop roll (beat repeat) block: loop store, capture and
// replay control, wet/dry mixer and handshakes. Depends on lrcr_pkg and
// lrcr_pos_mod.
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Handshake
// --------  --------------------------------------  ---------  ---------------
// request   req_active, req_left_in, req_right_in   in         req_valid/ready
// response  rsp_left_out, rsp_right_out             out        rsp_valid/ready
// csr       csr_index, csr_wdata                    in         csr_we
//
// Each request transaction yields exactly one response transaction, through
// stage one and the response register. One transaction is accepted per cycle
// while no position reduction runs and the response side is not stalled; the
// loop store has one write and one registered read port. Writing loop_frames
// starts a position reduction that blocks requests while it runs. Reset is
// synchronous; the loop store is not cleared, and its read data is used only
// for replay. A stalled response stays in its register while stage one can
// still take a new request, so throughput drops only while rsp_ready is low
// or a position reduction runs.

module loop_roll_capture_replay #(
   parameter int MAX_LOOP_FRAMES = 65536,
   parameter int CHANNELS        = 2,
   parameter int SAMPLE_BITS     = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_active,
   input  logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]       req_right_in,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_right_out,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [lrcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrcr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW     = $clog2(MAX_LOOP_FRAMES);
   localparam int LEN_W  = AW + 1;
   localparam int CMP_W  = (LEN_W > lrcr_pkg::FRAMES_W) ? LEN_W : lrcr_pkg::FRAMES_W;
   localparam int MEM_W  = CHANNELS * SAMPLE_BITS;
   localparam int PROD_W = SAMPLE_BITS + lrcr_pkg::WET_W + 1;
   localparam int SUM_W  = PROD_W + 1;

   // ---------------------------------------------------------------------
   // Configuration registers. A write to loop_frames schedules a reduction
   // of the play position by the new length, since the position only ever
   // enters the datapath modulo the length. The position itself is kept as
   // the last transaction left it, so every later write reduces it afresh.
   // ---------------------------------------------------------------------
   logic [lrcr_pkg::WET_W-1:0]    wet_gain_ff;
   logic [lrcr_pkg::FRAMES_W-1:0] loop_frames_ff;
   logic                          norm_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_gain_ff    <= lrcr_pkg::WET_GAIN_RST;
         loop_frames_ff <= lrcr_pkg::LOOP_FRAMES_RST;
         norm_start_ff  <= 1'b0;
      end else begin
         norm_start_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               lrcr_pkg::CSR_WET_GAIN: begin
                  wet_gain_ff <= csr_wdata[lrcr_pkg::WET_W-1:0];
               end
               lrcr_pkg::CSR_LOOP_FRAMES: begin
                  loop_frames_ff <= csr_wdata[lrcr_pkg::FRAMES_W-1:0];
                  norm_start_ff  <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Effective loop length: zero counts as one, and the store size caps it.
   logic [CMP_W-1:0] frames_ext;
   logic [LEN_W-1:0] eff_len;
   logic [lrcr_pkg::WET_W-1:0] wet_clamped;

   assign frames_ext = CMP_W'(loop_frames_ff);

   always_comb begin
      priority if (frames_ext == '0) begin
         eff_len = LEN_W'(1);
      end else if (frames_ext > CMP_W'(MAX_LOOP_FRAMES)) begin
         eff_len = LEN_W'(MAX_LOOP_FRAMES);
      end else begin
         eff_len = LEN_W'(frames_ext);
      end
   end

   assign wet_clamped = (wet_gain_ff > lrcr_pkg::WET_FULL) ? lrcr_pkg::WET_FULL : wet_gain_ff;

   // ---------------------------------------------------------------------
   // Play position reduction unit. pos_ff is the position as the last
   // transaction left it; slot_ff is that position modulo the current length
   // and is the store index the next transaction uses.
   // ---------------------------------------------------------------------
   logic [AW-1:0]          pos_ff, pos_in;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [AW-1:0]          pos_reduced;
   lrcr_pkg::mod_stat_type norm_stat;
   logic                   norm_busy;

   lrcr_pos_mod #(
      .POS_W (AW)
   ) u_pos_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (norm_start_ff),
      .numer     (pos_ff),
      .divisor   (eff_len),
      .remainder (pos_reduced),
      .stat      (norm_stat)
   );

   assign norm_busy = norm_start_ff || norm_stat.busy;

   // ---------------------------------------------------------------------
   // Handshake and pipeline control. Stage one holds an accepted request
   // while the loop store read completes; the response register follows.
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s1_advance;
   logic req_fire;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !norm_busy && (!s1_valid_ff || s1_advance);
   assign req_fire   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Capture and replay control, evaluated for the transaction being accepted.
   // A rising edge of active restarts capture from the first store entry.
   // ---------------------------------------------------------------------
   logic             cap_ff, cap_in;
   logic             was_active_ff;
   logic             rise;
   logic [AW-1:0]    idx;
   logic             cur_cap;
   logic [LEN_W-1:0] idx_next;
   logic             at_end;
   logic             store_we;

   assign rise     = req_active && !was_active_ff;
   assign idx      = rise ? '0 : slot_ff;
   assign cur_cap  = rise ? 1'b0 : cap_ff;
   assign idx_next = LEN_W'(idx) + LEN_W'(1);
   assign at_end   = (idx_next >= eff_len);
   assign store_we = req_fire && req_active && !cur_cap;

   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      cap_in  = cap_ff;
      if (norm_stat.done) begin
         slot_in = pos_reduced;
      end else if (req_fire && req_active) begin
         cap_in  = cur_cap || at_end;
         pos_in  = at_end ? '0 : idx_next[AW-1:0];
         slot_in = at_end ? '0 : idx_next[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         slot_ff       <= '0;
         cap_ff        <= 1'b0;
         was_active_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         slot_ff <= slot_in;
         cap_ff  <= cap_in;
         if (req_fire) begin
            was_active_ff <= req_active;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Loop store: one write port for capture, one registered read port.
   // The read register only loads on acceptance, so it stays paired with
   // the contents of stage one through any stall.
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] dry [2];
   logic [MEM_W-1:0]              store_wdata;
   logic [MEM_W-1:0]              store_mem [MAX_LOOP_FRAMES];
   logic [MEM_W-1:0]              store_rd_ff;

   assign dry[0] = req_left_in;
   assign dry[1] = req_right_in;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_wdata
      assign store_wdata[c*SAMPLE_BITS +: SAMPLE_BITS] = dry[c];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[idx] <= store_wdata;
      end
      if (req_fire) begin
         store_rd_ff <= store_mem[idx];
      end
   end

   // Stage one payload.
   logic                          s1_act_ff;
   logic                          s1_replay_ff;
   logic [lrcr_pkg::WET_W-1:0]    s1_wet_ff;
   logic signed [SAMPLE_BITS-1:0] s1_dry_ff [2];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_act_ff    <= req_active;
         s1_replay_ff <= req_active && cur_cap;
         s1_wet_ff    <= wet_clamped;
         s1_dry_ff[0] <= dry[0];
         s1_dry_ff[1] <= dry[1];
      end
   end

   // ---------------------------------------------------------------------
   // Wet/dry mixer for active requests: (dry*(256-wet) + loop*wet) >>> 8, per
   // channel; inactive requests pass through dry. During capture the loop sample
   // is the dry sample itself, and a channel beyond CHANNELS passes through dry.
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] mix_out [2];
   logic signed [lrcr_pkg::WET_W:0] gain_wet;
   logic signed [lrcr_pkg::WET_W:0] gain_dry;

   assign gain_wet = $signed({1'b0, s1_wet_ff});
   assign gain_dry = $signed({1'b0, lrcr_pkg::WET_FULL - s1_wet_ff});

   for (genvar c = 0; c < 2; c++) begin : g_mix
      if (c < CHANNELS) begin : g_lane
         logic signed [SAMPLE_BITS-1:0] loop_smp;
         logic signed [PROD_W-1:0]      prod_dry;
         logic signed [PROD_W-1:0]      prod_wet;
         logic signed [SUM_W-1:0]       mix_sum;

         assign loop_smp = s1_replay_ff ? $signed(store_rd_ff[c*SAMPLE_BITS +: SAMPLE_BITS])
                                        : s1_dry_ff[c];
         assign prod_dry = PROD_W'(s1_dry_ff[c]) * PROD_W'(gain_dry);
         assign prod_wet = PROD_W'(loop_smp) * PROD_W'(gain_wet);
         assign mix_sum  = SUM_W'(prod_dry) + SUM_W'(prod_wet);
         assign mix_out[c] = s1_act_ff
                           ? mix_sum[lrcr_pkg::MIX_SHIFT +: SAMPLE_BITS]
                           : s1_dry_ff[c];
      end else begin : g_pass
         assign mix_out[c] = s1_dry_ff[c];
      end
   end

   // Response register.
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_left_ff  <= mix_out[0];
         rsp_right_ff <= mix_out[1];
      end
   end

   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // Outside a reduction the store index is always within the loop length.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      !norm_busy |-> (LEN_W'(slot_ff) < eff_len))
      else $error("play position beyond loop length");

   // A transaction leaving stage one shows up on the response next cycle.
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("stage one transaction lost");

   // Finishing a capture always restarts replay at the first frame.
   a_capture_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(cap_ff) |-> (pos_ff == '0))
      else $error("replay did not start at frame zero");

endmodule
